// ----- design/iiel_pkg.sv -----
// Package for the indexed insert/erase list.
// Holds the sizes, the request function codes and the cell move codes.
// Used by the interfaces, the list cell and the top level.
`default_nettype none

package iiel_pkg;

   localparam int CAPACITY = 64;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      FUNC_GET          = 3'd0,
      FUNC_SET          = 3'd1,
      FUNC_APPEND       = 3'd2,
      FUNC_PREPEND      = 3'd3,
      FUNC_REMOVE_LAST  = 3'd4,
      FUNC_REMOVE_FIRST = 3'd5,
      FUNC_INSERT       = 3'd6,
      FUNC_ERASE        = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_FROM_LEFT  = 2'd2,
      CELL_FROM_RIGHT = 2'd3
   } cell_mode_type;

endpackage

`default_nettype wire

// ----- design/iiel_if.sv -----
// Valid/ready channel interfaces of the indexed insert/erase list.
// The request channel carries one request word, the response channel one result word.
// Depends on iiel_pkg for the field widths.
`default_nettype none

interface iiel_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [2:0]                           func;
   logic [iiel_pkg::POS_W-1:0]           position;
   logic signed [iiel_pkg::WORD_W-1:0]   word_in;

   modport source (output valid, output func, output position, output word_in, input ready);
   modport sink   (input valid, input func, input position, input word_in, output ready);
endinterface

interface iiel_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 ok;
   logic signed [iiel_pkg::WORD_W-1:0]   word_out;
   logic [iiel_pkg::COUNT_W-1:0]         count;

   modport source (output valid, output ok, output word_out, output count, input ready);
   modport sink   (input valid, input ok, input word_out, input count, output ready);
endinterface

`default_nettype wire

// ----- design/indexed_insert_erase_list_top.sv -----
// Top level of the indexed insert/erase list: request decode, element count,
// the row of list cells and the response register.
// Depends on iiel_pkg, iiel_if.sv and iiel_cell.
//
// Usage: a request word on req_ch names get, set, push back, push front,
// pop back, pop front, insert at a position, or erase at a position. Every
// request gives exactly one response word on rsp_ch: an ok flag, the element
// read or removed (zero otherwise), and the element count afterwards.
// The response is valid in the cycle after the request is accepted.
// Throughput is one request per cycle while no response is stalled, since
// every cell moves its element to its neighbor in the same cycle for
// insert and erase. The response register is the only stage; while a
// response waits and rsp_ch.ready is low, req_ch.ready is low and the list
// does not change. Reset clears the count and the response valid flag; the
// cell contents are not cleared, since only elements below the count are read.
`default_nettype none

module indexed_insert_erase_list_top (
   input  wire          clock,
   input  wire          reset,
   iiel_req_if.sink     req_ch,
   iiel_rsp_if.source   rsp_ch
);

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_OPEN  = 2'd2,
      ACT_CLOSE = 2'd3
   } action_type;

   localparam int CAP = iiel_pkg::CAPACITY;
   localparam int CW  = iiel_pkg::CMP_W;
   localparam int WW  = iiel_pkg::WORD_W;

   logic [iiel_pkg::CNT_W-1:0]     count_ff;
   logic [iiel_pkg::CNT_W-1:0]     count_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic                           rsp_ok_ff;
   logic [WW-1:0]                  rsp_word_ff;
   logic [iiel_pkg::COUNT_W-1:0]   rsp_count_ff;

   logic                           go;
   iiel_pkg::func_type             func;
   action_type                     act;
   logic                           op_ok;
   logic [CW-1:0]                  cnt_ext;
   logic [CW-1:0]                  pos_ext;
   logic [CW-1:0]                  eff_pos;
   logic                           full;
   logic                           empty;
   logic [WW-1:0]                  rd_word;
   logic [CW-1:0]                  cnt_next_ext;

   logic [WW-1:0]                  cell_word [CAP];
   iiel_pkg::cell_mode_type        cell_mode [CAP];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign go           = req_ch.valid && req_ch.ready;
   assign func         = iiel_pkg::func_type'(req_ch.func);
   assign cnt_ext      = CW'(count_ff);
   assign pos_ext      = CW'(req_ch.position);
   assign full         = (cnt_ext == CW'(CAP));
   assign empty        = (count_ff == '0);

   always_comb begin
      unique case (func)
         iiel_pkg::FUNC_GET: begin
            act = ACT_READ;  op_ok = (pos_ext < cnt_ext);  eff_pos = pos_ext;
         end
         iiel_pkg::FUNC_SET: begin
            act = ACT_WRITE; op_ok = (pos_ext < cnt_ext);  eff_pos = pos_ext;
         end
         iiel_pkg::FUNC_APPEND: begin
            act = ACT_OPEN;  op_ok = !full;                eff_pos = cnt_ext;
         end
         iiel_pkg::FUNC_PREPEND: begin
            act = ACT_OPEN;  op_ok = !full;                eff_pos = '0;
         end
         iiel_pkg::FUNC_REMOVE_LAST: begin
            act = ACT_CLOSE; op_ok = !empty;               eff_pos = cnt_ext - CW'(1);
         end
         iiel_pkg::FUNC_REMOVE_FIRST: begin
            act = ACT_CLOSE; op_ok = !empty;               eff_pos = '0;
         end
         iiel_pkg::FUNC_INSERT: begin
            act = ACT_OPEN;  op_ok = !full && (pos_ext <= cnt_ext); eff_pos = pos_ext;
         end
         default: begin
            act = ACT_CLOSE; op_ok = (pos_ext < cnt_ext);  eff_pos = pos_ext;
         end
      endcase
   end

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      localparam logic [CW-1:0] CELL_IDX = CW'(i);

      logic [WW-1:0] left_word;
      logic [WW-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_inner_left
         assign left_word = cell_word[i-1];
      end

      if (i == CAP - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_inner_right
         assign right_word = cell_word[i+1];
      end

      always_comb begin
         cell_mode[i] = iiel_pkg::CELL_HOLD;
         if (go && op_ok) begin
            unique case (act)
               ACT_WRITE: begin
                  if (CELL_IDX == eff_pos) cell_mode[i] = iiel_pkg::CELL_LOAD;
               end
               ACT_OPEN: begin
                  priority if (CELL_IDX == eff_pos) begin
                     cell_mode[i] = iiel_pkg::CELL_LOAD;
                  end else if (CELL_IDX > eff_pos && CELL_IDX <= cnt_ext) begin
                     cell_mode[i] = iiel_pkg::CELL_FROM_LEFT;
                  end
               end
               ACT_CLOSE: begin
                  if (CELL_IDX >= eff_pos) cell_mode[i] = iiel_pkg::CELL_FROM_RIGHT;
               end
               default: cell_mode[i] = iiel_pkg::CELL_HOLD;
            endcase
         end
      end

      iiel_cell u_cell (
         .clock      (clock),
         .mode       (cell_mode[i]),
         .left_word  (left_word),
         .right_word (right_word),
         .load_word  (req_ch.word_in),
         .word_ff    (cell_word[i])
      );
   end

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAP; i++) begin
         if (eff_pos == CW'(i)) rd_word = rd_word | cell_word[i];
      end
   end

   always_comb begin
      count_in     = count_ff;
      if (go && op_ok) begin
         unique case (act)
            ACT_OPEN:  count_in = count_ff + iiel_pkg::CNT_W'(1);
            ACT_CLOSE: count_in = count_ff - iiel_pkg::CNT_W'(1);
            default:   count_in = count_ff;
         endcase
      end
      cnt_next_ext = CW'(count_in);
      rsp_valid_in = go || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_ok_ff    <= op_ok;
         rsp_word_ff  <= (op_ok && (act == ACT_READ || act == ACT_CLOSE)) ? rd_word : '0;
         rsp_count_ff <= iiel_pkg::COUNT_W'(cnt_next_ext);
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.ok       = rsp_ok_ff;
   assign rsp_ch.word_out = rsp_word_ff;
   assign rsp_ch.count    = rsp_count_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      CW'(count_ff) <= CW'(CAP))
      else $error("Element count exceeds the capacity.");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      go && !op_ok |=> count_ff == $past(count_ff))
      else $error("A rejected request changed the element count.");

   a_stall_blocks_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("A request was taken while a response was stalled.");

   a_request_gives_response: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid_ff && rsp_count_ff == iiel_pkg::COUNT_W'(CW'(count_ff)))
      else $error("An accepted request did not give a matching response.");

endmodule

`default_nettype wire

// ----- design/iiel_cell.sv -----
// One storage cell of the list row: holds one element.
// Each cycle it holds, loads the request word, or takes a neighbor's element.
// Depends on iiel_pkg for the word width and the move codes.
`default_nettype none

module iiel_cell (
   input  wire                              clock,
   input  wire iiel_pkg::cell_mode_type     mode,
   input  wire [iiel_pkg::WORD_W-1:0]       left_word,
   input  wire [iiel_pkg::WORD_W-1:0]       right_word,
   input  wire [iiel_pkg::WORD_W-1:0]       load_word,
   output logic [iiel_pkg::WORD_W-1:0]      word_ff
);

   logic [iiel_pkg::WORD_W-1:0] word_in;

   always_comb begin
      unique case (mode)
         iiel_pkg::CELL_LOAD:       word_in = load_word;
         iiel_pkg::CELL_FROM_LEFT:  word_in = left_word;
         iiel_pkg::CELL_FROM_RIGHT: word_in = right_word;
         default:                   word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

`default_nettype wire
